/* hw/rtl/euler_vertex_rotator_macros.svh */
// Assertion helpers used by the checker file.
`ifndef EULER_VERTEX_ROTATOR_MACROS_SVH
`define EULER_VERTEX_ROTATOR_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define EVR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define EVR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/evr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_pkg
// Shared constants for the vertex rotator.
// ----------------------------------------------------------------------------
package evr_pkg;
  localparam int CoordW  = 24;
  localparam int AngleW  = 16;
  localparam int Iters   = 24;
  localparam int Guard   = 8;
  localparam int WorkW   = 36;
  localparam int StageW  = 27;
  localparam logic signed [CoordW-1:0] DepthReset = 24'sd393216;
  localparam logic signed [31:0] Gain = 32'sd652032874;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    begin
      unique case (i)
        0: r = 32'h20000000; 1: r = 32'h12E4051E; 2: r = 32'h09FB385B;
        3: r = 32'h051111D4; 4: r = 32'h028B0D43; 5: r = 32'h0145D7E1;
        6: r = 32'h00A2F61E; 7: r = 32'h00517C55; 8: r = 32'h0028BE53;
        9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
        12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
        15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
        18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
        21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction
endpackage

/* hw/rtl/evr_plane_rot.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_plane_rot
// Pipelined CORDIC plane rotation: a quadrant stage, one stage per pair of
// iterations, a gain multiply stage and a rounding stage.
// ----------------------------------------------------------------------------
module evr_plane_rot import evr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic signed [StageW-1:0] in_a,
  input  logic signed [StageW-1:0] in_b,
  input  logic [AngleW-1:0]        in_ang,
  input  logic [AngleW-1:0]        in_ang1,
  input  logic [AngleW-1:0]        in_ang2,
  input  logic signed [CoordW-1:0] in_c,
  output logic                     out_vld,
  output logic signed [StageW-1:0] out_a,
  output logic signed [StageW-1:0] out_b,
  output logic [AngleW-1:0]        out_ang1,
  output logic [AngleW-1:0]        out_ang2,
  output logic signed [CoordW-1:0] out_c
);
  localparam int Steps = Iters / 2;
  localparam int Depth = Steps + 3;

  logic                     vld_r [Depth];
  logic signed [WorkW-1:0]  a_r   [Steps+1];
  logic signed [WorkW-1:0]  b_r   [Steps+1];
  logic signed [33:0]       z_r   [Steps+1];
  logic [AngleW-1:0]        g1_r  [Depth];
  logic [AngleW-1:0]        g2_r  [Depth];
  logic signed [CoordW-1:0] c_r   [Depth];
  logic signed [67:0]       pa_r, pb_r;
  logic signed [StageW-1:0] ra_r, rb_r;

  logic [31:0]             turn;
  logic [1:0]              quad;
  logic [31:0]             rd;
  logic signed [WorkW-1:0] qa, qb;

  always_comb begin
    turn = {in_ang, {(32-AngleW){1'b0}}};
    quad = 2'((turn + 32'h20000000) >> 30);
    rd   = turn - {quad, 30'b0};
    unique case (quad)
      2'd1: begin qa = -WorkW'(in_b); qb = WorkW'(in_a); end
      2'd2: begin qa = -WorkW'(in_a); qb = -WorkW'(in_b); end
      2'd3: begin qa = WorkW'(in_b); qb = -WorkW'(in_a); end
      default: begin qa = WorkW'(in_a); qb = WorkW'(in_b); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < Depth; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < Depth; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= qa <<< Guard;
      b_r[0] <= qb <<< Guard;
      z_r[0] <= 34'(signed'(rd));
      g1_r[0] <= in_ang1;
      g2_r[0] <= in_ang2;
      c_r[0] <= in_c;
      for (int k = 1; k < Depth; k++) begin
        g1_r[k] <= g1_r[k-1];
        g2_r[k] <= g2_r[k-1];
        c_r[k] <= c_r[k-1];
      end
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic signed [WorkW-1:0] a1, b1, a2, b2;
    logic signed [33:0]      z1, z2;
    always_comb begin
      if (!z_r[s][33]) begin
        a1 = a_r[s] - (b_r[s] >>> (2*s)); b1 = b_r[s] + (a_r[s] >>> (2*s));
        z1 = z_r[s] - 34'(atan_turn(2*s));
      end else begin
        a1 = a_r[s] + (b_r[s] >>> (2*s)); b1 = b_r[s] - (a_r[s] >>> (2*s));
        z1 = z_r[s] + 34'(atan_turn(2*s));
      end
      if (!z1[33]) begin
        a2 = a1 - (b1 >>> (2*s+1)); b2 = b1 + (a1 >>> (2*s+1));
        z2 = z1 - 34'(atan_turn(2*s+1));
      end else begin
        a2 = a1 + (b1 >>> (2*s+1)); b2 = b1 - (a1 >>> (2*s+1));
        z2 = z1 + 34'(atan_turn(2*s+1));
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        a_r[s+1] <= a2;
        b_r[s+1] <= b2;
        z_r[s+1] <= z2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= 68'(a_r[Steps]) * 68'(Gain);
      pb_r <= 68'(b_r[Steps]) * 68'(Gain);
      ra_r <= StageW'((pa_r + (68'sd1 <<< 37)) >>> 38);
      rb_r <= StageW'((pb_r + (68'sd1 <<< 37)) >>> 38);
    end
  end

  assign out_vld  = vld_r[Depth-1];
  assign out_a    = ra_r;
  assign out_b    = rb_r;
  assign out_ang1 = g1_r[Depth-1];
  assign out_ang2 = g2_r[Depth-1];
  assign out_c    = c_r[Depth-1];
endmodule

/* hw/rtl/euler_vertex_rotator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_vertex_rotator
// Rotates a vertex by roll, pitch and yaw and adds a depth offset to x.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries a vertex and three
// binary angles; the output channel (out_valid/out_ready) returns the rotated
// vertex with a saturation flag. One transfer is accepted per cycle.
// Three rotation units of 15 stages each (quadrant, twelve two-iteration
// CORDIC stages, gain multiply, rounding) are followed by the output
// register, which also adds the offset and saturates.
// Throughput is one vertex per cycle, set by the fully unrolled CORDIC.
// The pipeline advances as a whole; when the receiver stalls with a result
// waiting, all stages hold and in_ready falls until the result is taken.
// cfg_depth_offset_we writes the depth offset; write it only while idle.
// Synchronous reset clears all valid bits and restores the offset to 6.0.
// ----------------------------------------------------------------------------
module euler_vertex_rotator import evr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] in_vertex_x,
  input  logic signed [CoordW-1:0] in_vertex_y,
  input  logic signed [CoordW-1:0] in_vertex_z,
  input  logic [AngleW-1:0]        in_roll_angle,
  input  logic [AngleW-1:0]        in_pitch_angle,
  input  logic [AngleW-1:0]        in_yaw_angle,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CoordW-1:0] out_rotated_x,
  output logic signed [CoordW-1:0] out_rotated_y,
  output logic signed [CoordW-1:0] out_rotated_z,
  output logic                     out_overflow,
  input  logic                     cfg_depth_offset_we,
  input  logic signed [CoordW-1:0] cfg_depth_offset
);
  logic signed [CoordW-1:0] depth_r;
  logic en;
  logic v1, v2, v3;
  logic signed [StageW-1:0] a1, b1, a2, b2, a3, b3;
  logic [AngleW-1:0] p1, w1, w2, u1, u2;
  logic signed [CoordW-1:0] c1, c2;
  logic signed [CoordW-1:0] ox_r, oy_r, oz_r;
  logic ov_r, vld_r;
  logic signed [StageW:0] sx;
  logic signed [CoordW-1:0] cx, cy, cz;
  logic fx, fy, fz;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DepthReset;
    end else if (cfg_depth_offset_we) begin
      depth_r <= cfg_depth_offset;
    end
  end

  evr_plane_rot u_roll (
    .clk, .rst_n, .en, .in_vld(in_valid),
    .in_a(StageW'(in_vertex_y)), .in_b(StageW'(in_vertex_z)),
    .in_ang(in_roll_angle), .in_ang1(in_pitch_angle), .in_ang2(in_yaw_angle),
    .in_c(in_vertex_x),
    .out_vld(v1), .out_a(a1), .out_b(b1), .out_ang1(p1), .out_ang2(w1), .out_c(c1)
  );

  // Pair (x,z); y, now wider, bypasses this unit in a delay line and goes through the yaw a lane.
  evr_plane_rot u_pitch (
    .clk, .rst_n, .en, .in_vld(v1),
    .in_a(StageW'(c1)), .in_b(b1),
    .in_ang(p1), .in_ang1(w1), .in_ang2(u1),
    .in_c(CoordW'(0)),
    .out_vld(v2), .out_a(a2), .out_b(b2), .out_ang1(w2), .out_ang2(u2), .out_c(c2)
  );

  assign u1 = '0;

  logic signed [StageW-1:0] y_dly_r [15];
  always_ff @(posedge clk) begin
    if (en) begin
      y_dly_r[0] <= a1;
      for (int k = 1; k < 15; k++) y_dly_r[k] <= y_dly_r[k-1];
    end
  end

  logic signed [StageW-1:0] z_dly_r [15];
  always_ff @(posedge clk) begin
    if (en) begin
      z_dly_r[0] <= b2;
      for (int k = 1; k < 15; k++) z_dly_r[k] <= z_dly_r[k-1];
    end
  end

  evr_plane_rot u_yaw (
    .clk, .rst_n, .en, .in_vld(v2),
    .in_a(y_dly_r[14]), .in_b(a2),
    .in_ang(w2), .in_ang1(u2), .in_ang2(u2),
    .in_c(c2),
    .out_vld(v3), .out_a(a3), .out_b(b3), .out_ang1(), .out_ang2(), .out_c()
  );

  always_comb begin
    sx = (StageW+1)'(b3) + (StageW+1)'(depth_r);
    fx = (sx > (StageW+1)'(8388607)) || (sx < -(StageW+1)'(8388608));
    cx = (sx > (StageW+1)'(8388607)) ? 24'sh7FFFFF :
         (sx < -(StageW+1)'(8388608)) ? 24'sh800000 : CoordW'(sx);
    fy = (a3 > StageW'(8388607)) || (a3 < -StageW'(8388608));
    cy = (a3 > StageW'(8388607)) ? 24'sh7FFFFF :
         (a3 < -StageW'(8388608)) ? 24'sh800000 : CoordW'(a3);
    fz = (z_dly_r[14] > StageW'(8388607)) || (z_dly_r[14] < -StageW'(8388608));
    cz = (z_dly_r[14] > StageW'(8388607)) ? 24'sh7FFFFF :
         (z_dly_r[14] < -StageW'(8388608)) ? 24'sh800000 : CoordW'(z_dly_r[14]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= cx;
      oy_r <= cy;
      oz_r <= cz;
      ov_r <= fx || fy || fz;
    end
  end

  assign out_valid     = vld_r;
  assign out_rotated_x = ox_r;
  assign out_rotated_y = oy_r;
  assign out_rotated_z = oz_r;
  assign out_overflow  = ov_r;
endmodule

/* hw/rtl/evr_checker.sv */
`timescale 1ns / 1ps
`include "euler_vertex_rotator_macros.svh"
// ----------------------------------------------------------------------------
// evr_checker
// Port-level checks for the vertex rotator.
// ----------------------------------------------------------------------------
module evr_checker import evr_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [CoordW-1:0] out_rotated_x,
  input logic                     out_overflow
);
  `EVR_ASSERT_IMP(a_ready_when_free, !out_valid, in_ready)
  `EVR_ASSERT_IMP(a_stall_blocks, out_valid && !out_ready, !in_ready)
  `EVR_ASSERT_NXT(a_hold_valid, out_valid && !out_ready, out_valid && $stable(out_rotated_x))
  `EVR_ASSERT_NXT(a_hold_flag, out_valid && !out_ready, $stable(out_overflow))
endmodule

bind euler_vertex_rotator evr_checker u_evr_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_rotated_x, .out_overflow
);
